/* rtl/bhlc_pkg.sv */
// Package for the cascaded high-pass / low-pass biquad filter core.
// Holds widths, register indexes, reset coefficients, tap codes and sequencer types.
// No dependencies; every other file in rtl/ imports it.
package bhlc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    // Five products of 34 bits each need 37 bits; one guard bit on top.
    localparam int ACC_W     = PROD_W + 4;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int CFG_IDX_W = REG_IDX_W + 1;
    localparam int NUM_TAPS  = 5;
    localparam int TAP_W     = $clog2(NUM_TAPS);

    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [TAP_W-1:0]           tap_t;

    // Register indexes of the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_HP_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HP_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HP_A1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HP_A2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LP_B0 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LP_B1 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LP_A1 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LP_A2 = 3'd7;

    localparam coef_t COEF_RESET [NUM_REGS] = '{
        18'sd62688,  -18'sd125375, -18'sd125252, 18'sd59963,
        18'sd37290,  18'sd74581,   18'sd61785,   18'sd21841
    };

    // Tap order within one section: feedforward first, then the feedback terms.
    localparam tap_t TAP_X0 = 3'd0;
    localparam tap_t TAP_X1 = 3'd1;
    localparam tap_t TAP_X2 = 3'd2;
    localparam tap_t TAP_Y1 = 3'd3;
    localparam tap_t TAP_Y2 = 3'd4;

    localparam logic SECT_HP = 1'b0;
    localparam logic SECT_LP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_WB,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic mul_en;  // multiply the selected coefficient and sample this cycle
        logic clr;     // this product starts a fresh accumulation
        logic neg;     // this product is subtracted
        tap_t tap;     // operand pair select
        logic sect;    // section being computed
        logic wb;      // section result is final, update history
    } seq_ctrl_t;

endpackage

/* rtl/bhlc_mac.sv */
// Shared multiply-accumulate unit with rounding and 16-bit saturation.
// One registered 18x16 multiplier feeding a 38-bit accumulator; uses bhlc_pkg.
module bhlc_mac #(
    parameter int COEF_FRAC_BITS = bhlc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mul_en,
    input  logic             clr,
    input  logic             neg,
    input  bhlc_pkg::coef_t   coef,
    input  bhlc_pkg::sample_t data,
    output bhlc_pkg::sample_t result
);
    import bhlc_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     acc_en_reg;
    logic                     clr_d_reg;
    logic                     neg_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;

    assign prod_next = coef * data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
            clr_d_reg  <= 1'b0;
            neg_d_reg  <= 1'b0;
        end
        else
        begin
            acc_en_reg <= mul_en;
            clr_d_reg  <= clr;
            neg_d_reg  <= neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (acc_en_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_base = clr_d_reg ? '0 : acc_reg;
        acc_next = neg_d_reg ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end

    // Round half up, floor by arithmetic shift, then clamp to the sample range.
    always_comb
    begin
        rounded = acc_reg + ROUND_BIAS;
        shifted = rounded >>> COEF_FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            result = sample_t'(SAMPLE_MAX);
        end
        else if (shifted < SAT_LO)
        begin
            result = sample_t'(SAMPLE_MIN);
        end
        else
        begin
            result = shifted[SAMPLE_W-1:0];
        end
    end

    a_acc_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_en |=> acc_en_reg)
        else $error("accumulate did not follow a multiply");

    a_clr_delayed: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_en && clr) |=> (acc_en_reg && clr_d_reg))
        else $error("accumulator clear lost in the product stage");

    a_neg_delayed: assert property (@(posedge clk) disable iff (!rst_n)
        mul_en |=> (neg_d_reg == $past(neg)))
        else $error("subtract flag out of step with its product");

endmodule

/* rtl/bhlc_seq.sv */
// Sequencer that steps the shared MAC through five taps of each section in turn.
// Drives the request handshakes of both channels; uses bhlc_pkg.
module bhlc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output bhlc_pkg::seq_ctrl_t ctrl
);
    import bhlc_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    tap_t       tap_reg;
    tap_t       tap_next;
    logic       sect_reg;
    logic       sect_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= TAP_X0;
            sect_reg  <= SECT_HP;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            sect_reg  <= sect_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        sect_next   = sect_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        ctrl.mul_en = 1'b0;
        ctrl.clr    = (tap_reg == TAP_X0);
        ctrl.neg    = (tap_reg == TAP_Y1) || (tap_reg == TAP_Y2);
        ctrl.tap    = tap_reg;
        ctrl.sect   = sect_reg;
        ctrl.wb     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    tap_next   = TAP_X0;
                    sect_next  = SECT_HP;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                if (tap_reg == TAP_Y2)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + tap_t'(1);
                end
            end
            ST_DRAIN:
            begin
                // The last product is added into the accumulator here.
                state_next = ST_WB;
            end
            ST_WB:
            begin
                ctrl.wb = 1'b1;
                if (sect_reg == SECT_HP)
                begin
                    sect_next  = SECT_LP;
                    tap_next   = TAP_X0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_start_hp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=>
            (state_reg == ST_MUL && tap_reg == TAP_X0 && sect_reg == SECT_HP))
        else $error("accepted request did not start the high-pass section");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("new request taken while a result is pending");

    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result offered twice");

    a_wb_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wb |-> ($past(state_reg) == ST_DRAIN))
        else $error("section written back before its last product was added");

endmodule

/* rtl/biquad_highpass_lowpass_cascade_core.sv */
// Top level of the two-section biquad filter: high-pass then low-pass, direct form I.
// Holds coefficient registers and section history; uses bhlc_pkg, bhlc_seq, bhlc_mac.
//
// Channel  Direction  Handshake               Payload
// in       into core  in_valid / in_stall     sample_in  (16-bit signed)
// out      from core  out_valid / out_stall   sample_out (16-bit signed)
// cfg      into core  cfg_valid / cfg_ready   cfg_index, cfg_data (18-bit signed)
//
// A request is accepted in the idle state; then, per section, five multiplies, one
// accumulate and one write-back run on the single shared multiplier, then the result is
// offered. Output stalls hold the result; a new request is taken only after the result
// has left. Reset loads the default coefficients and clears all history. Configuration
// writes are always taken.
module biquad_highpass_lowpass_cascade_core #(
    parameter int COEF_FRAC_BITS = bhlc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bhlc_pkg::sample_t                  sample_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bhlc_pkg::sample_t                  sample_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bhlc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  bhlc_pkg::coef_t                    cfg_data
);
    import bhlc_pkg::*;

    seq_ctrl_t ctrl;
    coef_t     coef_reg [NUM_REGS];
    sample_t   x_reg;
    sample_t   out_reg;
    sample_t   hp_x1_reg, hp_x2_reg, hp_y1_reg, hp_y2_reg;
    sample_t   lp_x1_reg, lp_x2_reg, lp_y1_reg, lp_y2_reg;
    coef_t     mac_coef;
    sample_t   mac_data;
    sample_t   sect_result;
    logic [REG_IDX_W-1:0] coef_sel;

    assign cfg_ready  = 1'b1;
    assign sample_out = out_reg;

    bhlc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    bhlc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .mul_en (ctrl.mul_en),
        .clr    (ctrl.clr),
        .neg    (ctrl.neg),
        .coef   (mac_coef),
        .data   (mac_data),
        .result (sect_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            coef_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_x1_reg <= '0;
            hp_x2_reg <= '0;
            hp_y1_reg <= '0;
            hp_y2_reg <= '0;
            lp_x1_reg <= '0;
            lp_x2_reg <= '0;
            lp_y1_reg <= '0;
            lp_y2_reg <= '0;
        end
        else if (ctrl.wb)
        begin
            if (ctrl.sect == SECT_HP)
            begin
                hp_x2_reg <= hp_x1_reg;
                hp_x1_reg <= x_reg;
                hp_y2_reg <= hp_y1_reg;
                hp_y1_reg <= sect_result;
            end
            else
            begin
                lp_x2_reg <= lp_x1_reg;
                lp_x1_reg <= x_reg;
                lp_y2_reg <= lp_y1_reg;
                lp_y1_reg <= sect_result;
            end
        end
    end

    // x_reg is the current section's input: the raw sample, then the high-pass output.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            x_reg <= sample_in;
        end
        else if (ctrl.wb && ctrl.sect == SECT_HP)
        begin
            x_reg <= sect_result;
        end
        if (ctrl.wb && ctrl.sect == SECT_LP)
        begin
            out_reg <= sect_result;
        end
    end

    always_comb
    begin
        unique case (ctrl.tap)
            TAP_X0:
            begin
                coef_sel = (ctrl.sect == SECT_HP) ? REG_HP_B0 : REG_LP_B0;
                mac_data = x_reg;
            end
            TAP_X1:
            begin
                coef_sel = (ctrl.sect == SECT_HP) ? REG_HP_B1 : REG_LP_B1;
                mac_data = (ctrl.sect == SECT_HP) ? hp_x1_reg : lp_x1_reg;
            end
            TAP_X2:
            begin
                coef_sel = (ctrl.sect == SECT_HP) ? REG_HP_B0 : REG_LP_B0;
                mac_data = (ctrl.sect == SECT_HP) ? hp_x2_reg : lp_x2_reg;
            end
            TAP_Y1:
            begin
                coef_sel = (ctrl.sect == SECT_HP) ? REG_HP_A1 : REG_LP_A1;
                mac_data = (ctrl.sect == SECT_HP) ? hp_y1_reg : lp_y1_reg;
            end
            TAP_Y2:
            begin
                coef_sel = (ctrl.sect == SECT_HP) ? REG_HP_A2 : REG_LP_A2;
                mac_data = (ctrl.sect == SECT_HP) ? hp_y2_reg : lp_y2_reg;
            end
            default:
            begin
                coef_sel = REG_HP_B0;
                mac_data = '0;
            end
        endcase
        mac_coef = coef_reg[coef_sel];
    end

endmodule
